>>> hw/rtl/basic_statement_execute_unit_core_defines.svh
// Assertion macros for the RTL of the statement execute unit.
`ifndef BASIC_STATEMENT_EXECUTE_UNIT_CORE_DEFINES_SVH
`define BASIC_STATEMENT_EXECUTE_UNIT_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define BSE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define BSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/bseu_pkg.sv
// ----------------------------------------------------------------------------
// bseu_pkg
// Opcodes, error codes, comparison codes and command types of the
// statement execute unit.
// ----------------------------------------------------------------------------
package bseu_pkg;

  // Size of the variable file; the 4-bit index fields fix it.
  localparam int NUM_VARS = 16;

  localparam logic [3:0] MODE_LET    = 4'd0;
  localparam logic [3:0] MODE_PRINT  = 4'd1;
  localparam logic [3:0] MODE_PALL   = 4'd2;
  localparam logic [3:0] MODE_ADD    = 4'd3;
  localparam logic [3:0] MODE_SUB    = 4'd4;
  localparam logic [3:0] MODE_MUL    = 4'd5;
  localparam logic [3:0] MODE_DIV    = 4'd6;
  localparam logic [3:0] MODE_END    = 4'd7;
  localparam logic [3:0] MODE_GOTO   = 4'd8;
  localparam logic [3:0] MODE_IF     = 4'd9;
  localparam logic [3:0] MODE_GOSUB  = 4'd10;
  localparam logic [3:0] MODE_RETURN = 4'd11;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_DIV0  = 3'd1;
  localparam logic [2:0] ERR_RANGE = 3'd2;
  localparam logic [2:0] ERR_EMPTY = 3'd3;
  localparam logic [2:0] ERR_FULL  = 3'd4;

  localparam logic [2:0] CMP_LT = 3'd0;
  localparam logic [2:0] CMP_LE = 3'd1;
  localparam logic [2:0] CMP_GT = 3'd2;
  localparam logic [2:0] CMP_GE = 3'd3;
  localparam logic [2:0] CMP_EQ = 3'd4;
  localparam logic [2:0] CMP_NE = 3'd5;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;       // capture the input transaction
    logic exec;       // compute the statement result
    logic div_start;  // open the divider
    logic div_step;   // one restoring step
    logic div_finish; // write quotient back
    logic scan_step;  // test next variable for print all
    logic pop_rd;     // read the top of the return stack
    logic pop_done;   // finish the return
    logic emit;       // load the output register
    logic emit_last;  // emit carries last
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [3:0] mode;
    logic       div_zero;
    logic       div_done;
    logic       scan_hit;   // variable under the scan pointer is defined
    logic       scan_end;   // scan pointer at the last defined variable
    logic       any_def;    // some variable is defined
    logic       stack_empty;
  } stat_t;

endpackage

>>> hw/rtl/bseu_ctrl.sv
// ----------------------------------------------------------------------------
// bseu_ctrl
// Sequencer of the statement execute unit: steps load, execute, divide,
// return pop, print-all scan and result handoff.
// ----------------------------------------------------------------------------
`include "basic_statement_execute_unit_core_defines.svh"

module bseu_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            out_full,
  output bseu_pkg::cmd_t  cmd,
  input  bseu_pkg::stat_t stat
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_POP  = 3'd4;
  localparam logic [2:0] S_WAIT = 3'd5;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_full) begin
          if (stat.mode == bseu_pkg::MODE_DIV) begin
            if (stat.div_zero) begin
              cmd.exec = 1'b1; cmd.emit = 1'b1; cmd.emit_last = 1'b1;
              state_next = S_IDLE;
            end else begin
              cmd.div_start = 1'b1;
              state_next    = S_DIV;
            end
          end else if (stat.mode == bseu_pkg::MODE_PALL) begin
            cmd.exec = 1'b1;
            if (stat.any_def) begin
              state_next = S_SCAN;
            end else begin
              cmd.emit = 1'b1; cmd.emit_last = 1'b1;
              state_next = S_IDLE;
            end
          end else if (stat.mode == bseu_pkg::MODE_RETURN && !stat.stack_empty) begin
            cmd.pop_rd = 1'b1;
            state_next = S_POP;
          end else begin
            cmd.exec = 1'b1; cmd.emit = 1'b1; cmd.emit_last = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          if (!out_full) begin
            cmd.div_finish = 1'b1; cmd.emit = 1'b1; cmd.emit_last = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_POP: begin
        if (!out_full) begin
          cmd.pop_done = 1'b1; cmd.emit = 1'b1; cmd.emit_last = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat.scan_hit) begin
          state_next = S_WAIT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_WAIT: begin
        if (!out_full) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = stat.scan_end;
          cmd.scan_step = 1'b1;
          state_next    = stat.scan_end ? S_IDLE : S_SCAN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `BSE_ASSERT_IMP(a_emit_room, clk, rst, cmd.emit, !out_full, "emit into full output")
  `BSE_ASSERT_IMP(a_load_idle, clk, rst, cmd.load, state == S_IDLE, "load outside idle")
  `BSE_ASSERT_NEXT(a_last_idle, clk, rst, cmd.emit && cmd.emit_last, state == S_IDLE,
                   "last result not closing the statement")

endmodule

>>> hw/rtl/bseu_dp.sv
// ----------------------------------------------------------------------------
// bseu_dp
// Datapath: variable file, line counter, return stack, radix-2 divider,
// print-all pointer and the output register.
// ----------------------------------------------------------------------------
module bseu_dp #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [15:0]            cfg_data,
  input  logic [3:0]             mode,
  input  logic [3:0]             target_var,
  input  logic                   src_is_var,
  input  logic [3:0]             src_var,
  input  logic signed [31:0]     literal,
  input  logic [2:0]             cmp_op,
  input  logic signed [31:0]     line,
  input  bseu_pkg::cmd_t         cmd,
  output bseu_pkg::stat_t        stat,
  output logic                   out_full,
  input  logic                   out_take,
  output logic signed [31:0]     counter_now,
  output logic                   print_valid,
  output logic [3:0]             print_index,
  output logic signed [31:0]     print_value,
  output logic [2:0]             error,
  output logic                   last
);

  localparam int NUM_VARS = bseu_pkg::NUM_VARS;
  localparam int VW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
  localparam int SW = $clog2(STACK_DEPTH + 1);
  localparam int PW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [31:0]   var_value [NUM_VARS];
  logic [NUM_VARS-1:0] var_defined;
  logic [31:0]   line_counter;
  logic [31:0]   return_stack [STACK_DEPTH];
  logic [SW-1:0] stack_depth;
  logic [15:0]   last_line;

  // captured transaction
  logic [3:0]  r_mode;
  logic [VW-1:0] r_t;
  logic [31:0] r_a;     // target value (0 if undefined)
  logic [31:0] r_b;     // operand
  logic [31:0] r_lit;
  logic [2:0]  r_cmp;
  logic [31:0] r_line;
  logic [31:0] pop_line;

  // divider
  logic [31:0] dv_q, dv_rem, dv_div;
  logic [5:0]  dv_cnt;
  logic        dv_an, dv_bn;

  logic [VW-1:0] scan;

  logic [VW-1:0] t_idx, s_idx;
  assign t_idx = VW'(32'(target_var) % NUM_VARS);
  assign s_idx = VW'(32'(src_var) % NUM_VARS);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_mode <= mode;
      r_t    <= t_idx;
      r_a    <= var_defined[t_idx] ? var_value[t_idx] : 32'd0;
      r_b    <= src_is_var ? (var_defined[s_idx] ? var_value[s_idx] : 32'd0) : literal;
      r_lit  <= literal;
      r_cmp  <= cmp_op;
      r_line <= line;
    end
    if (cmd.pop_rd) pop_line <= return_stack[PW'(stack_depth - SW'(1))] + 32'd1;
  end

  // statement evaluation
  logic        cond;
  logic [31:0] jmp_tgt;
  logic        range_bad;
  logic signed [31:0] sa, sl;
  assign sa = r_a;
  assign sl = r_lit;

  always_comb begin
    case (r_cmp)
      bseu_pkg::CMP_LT: cond = sa <  sl;
      bseu_pkg::CMP_LE: cond = sa <= sl;
      bseu_pkg::CMP_GT: cond = sa >  sl;
      bseu_pkg::CMP_GE: cond = sa >= sl;
      bseu_pkg::CMP_EQ: cond = sa == sl;
      bseu_pkg::CMP_NE: cond = sa != sl;
      default:          cond = 1'b0;
    endcase
  end

  assign jmp_tgt   = cmd.pop_done ? pop_line : r_line;
  assign range_bad = jmp_tgt[31] || (jmp_tgt > {16'd0, last_line});

  logic [31:0] mul_lo;
  assign mul_lo = r_a * r_b;

  logic        stack_full;
  assign stack_full = (stack_depth == SW'(STACK_DEPTH));

  logic [2:0]  ex_err;
  logic [31:0] ex_cnt;
  logic        ex_wr;
  logic [31:0] ex_val;
  logic        ex_push;

  always_comb begin
    ex_err  = bseu_pkg::ERR_NONE;
    ex_cnt  = line_counter;
    ex_wr   = 1'b0;
    ex_val  = r_a;
    ex_push = 1'b0;
    case (r_mode)
      bseu_pkg::MODE_LET:   begin ex_wr = 1'b1; ex_val = r_lit; ex_cnt = line_counter + 1; end
      bseu_pkg::MODE_PRINT: begin ex_wr = 1'b1; ex_cnt = line_counter + 1; end
      bseu_pkg::MODE_PALL:  ex_cnt = line_counter + 1;
      bseu_pkg::MODE_ADD:   begin ex_wr = 1'b1; ex_val = r_a + r_b; ex_cnt = line_counter + 1; end
      bseu_pkg::MODE_SUB:   begin ex_wr = 1'b1; ex_val = r_a - r_b; ex_cnt = line_counter + 1; end
      bseu_pkg::MODE_MUL:   begin ex_wr = 1'b1; ex_val = mul_lo; ex_cnt = line_counter + 1; end
      bseu_pkg::MODE_DIV:   begin ex_cnt = 32'd0; ex_err = bseu_pkg::ERR_DIV0; end
      bseu_pkg::MODE_END:   ex_cnt = 32'd0;
      bseu_pkg::MODE_GOTO:  begin
        ex_cnt = jmp_tgt; ex_err = range_bad ? bseu_pkg::ERR_RANGE : bseu_pkg::ERR_NONE;
      end
      bseu_pkg::MODE_IF: begin
        if (cond) begin
          ex_cnt = jmp_tgt; ex_err = range_bad ? bseu_pkg::ERR_RANGE : bseu_pkg::ERR_NONE;
        end
      end
      bseu_pkg::MODE_GOSUB: begin
        if (stack_full) ex_err = bseu_pkg::ERR_FULL;
        else begin
          ex_push = 1'b1; ex_cnt = jmp_tgt;
          ex_err  = range_bad ? bseu_pkg::ERR_RANGE : bseu_pkg::ERR_NONE;
        end
      end
      bseu_pkg::MODE_RETURN: ex_err = bseu_pkg::ERR_EMPTY;
      default: ;
    endcase
  end

  // divider: magnitude restoring division, fixed up to floor at the end
  logic [32:0] dv_trial;
  logic [31:0] dv_qm, dv_res;
  assign dv_trial = {dv_rem, dv_q[31]} - {1'b0, dv_div};
  assign dv_qm    = dv_an ^ dv_bn ? (32'd0 - dv_q) : dv_q;
  assign dv_res   = (dv_an ^ dv_bn) && (dv_rem != 32'd0) ? dv_qm - 32'd1 : dv_qm;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dv_an  <= r_a[31];
      dv_bn  <= r_b[31];
      dv_q   <= r_a[31] ? 32'd0 - r_a : r_a;
      dv_div <= r_b[31] ? 32'd0 - r_b : r_b;
      dv_rem <= 32'd0;
      dv_cnt <= 6'd0;
    end else if (cmd.div_step) begin
      if (!dv_trial[32]) begin
        dv_rem <= dv_trial[31:0];
        dv_q   <= {dv_q[30:0], 1'b1};
      end else begin
        dv_rem <= {dv_rem[30:0], dv_q[31]};
        dv_q   <= {dv_q[30:0], 1'b0};
      end
      dv_cnt <= dv_cnt + 6'd1;
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      var_defined  <= '0;
      line_counter <= 32'd1;
      stack_depth  <= '0;
      last_line    <= 16'd0;
      scan         <= '0;
    end else begin
      if (cfg_we) last_line <= cfg_data;
      if (cmd.exec) begin
        line_counter <= ex_cnt;
        if (ex_wr) var_defined[r_t] <= 1'b1;
        if (ex_push) stack_depth <= stack_depth + SW'(1);
        scan <= '0;
      end
      if (cmd.div_finish) begin
        var_defined[r_t] <= 1'b1;
        line_counter     <= line_counter + 32'd1;
      end
      if (cmd.pop_done) begin
        line_counter <= pop_line;
        stack_depth  <= stack_depth - SW'(1);
      end
      if (cmd.scan_step) scan <= scan + VW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && ex_wr) var_value[r_t] <= ex_val;
    if (cmd.div_finish) var_value[r_t] <= dv_res;
    if (cmd.exec && ex_push) return_stack[PW'(stack_depth)] <= line_counter;
  end

  // status
  logic [VW-1:0] last_def;
  always_comb begin
    last_def = '0;
    for (int i = 0; i < NUM_VARS; i++) if (var_defined[i]) last_def = VW'(i);
  end

  assign stat.mode        = r_mode;
  assign stat.div_zero    = (r_b == 32'd0);
  assign stat.div_done    = (dv_cnt == 6'd32);
  assign stat.scan_hit    = var_defined[scan];
  assign stat.scan_end    = (scan == last_def);
  assign stat.any_def     = |var_defined;
  assign stat.stack_empty = (stack_depth == '0);

  // output register
  logic        pv;
  logic [31:0] pval;
  logic [2:0]  perr;
  logic [31:0] pcnt;
  always_comb begin
    pv   = 1'b0;
    pval = 32'd0;
    perr = bseu_pkg::ERR_NONE;
    pcnt = line_counter;
    if (cmd.exec) begin
      perr = ex_err; pcnt = ex_cnt;
      if (r_mode == bseu_pkg::MODE_PRINT) begin pv = 1'b1; pval = r_a; end
    end else if (cmd.div_finish) begin
      pcnt = line_counter + 32'd1;
    end else if (cmd.pop_done) begin
      pcnt = pop_line; perr = range_bad ? bseu_pkg::ERR_RANGE : bseu_pkg::ERR_NONE;
    end else if (r_mode == bseu_pkg::MODE_PALL) begin
      pv = 1'b1; pval = var_value[scan];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_full <= 1'b0;
    else if (cmd.emit) out_full <= 1'b1;
    else if (out_take) out_full <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      counter_now <= pcnt;
      print_valid <= pv;
      print_index <= pv ? 4'(cmd.exec ? r_t : scan) : 4'd0;
      print_value <= pval;
      error       <= perr;
      last        <= cmd.emit_last;
    end
  end

endmodule

>>> hw/rtl/basic_statement_execute_unit_core.sv
// ----------------------------------------------------------------------------
// basic_statement_execute_unit_core
// Executes one statement of a line-numbered interpreter per transaction.
//
//   channel  | valid     | stall      | payload
//   ---------+-----------+------------+-------------------------------------
//   input    | in_valid  | in_stall   | mode .. line
//   output   | out_valid | out_stall  | counter_now .. last
//   config   | cfg_we    | -          | cfg_data (last_line)
//
// Steps: most statements are loaded, executed and handed off; a floor
// divide by nonzero runs the one-bit-per-cycle restoring divider before
// handoff; print-all scans the variables and emits each defined one.
// Reset: synchronous, clears the defined marks, counter to 1, stack empty.
// Stalls: the output register holds one result; the sequencer waits for room
// before each emit and takes no new transaction until the statement ends.
// ----------------------------------------------------------------------------
module basic_statement_execute_unit_core #(
  parameter int STACK_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         mode,
  input  logic [3:0]         target_var,
  input  logic               src_is_var,
  input  logic [3:0]         src_var,
  input  logic signed [31:0] literal,
  input  logic [2:0]         cmp_op,
  input  logic signed [31:0] line,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] counter_now,
  output logic               print_valid,
  output logic [3:0]         print_index,
  output logic signed [31:0] print_value,
  output logic [2:0]         error,
  output logic               last
);

  bseu_pkg::cmd_t  cmd;
  bseu_pkg::stat_t stat;
  logic            out_full;

  // present the output register; drop it when taken
  assign out_valid = out_full;

  bseu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_full (out_full),
    .cmd      (cmd),
    .stat     (stat)
  );

  bseu_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .mode        (mode),
    .target_var  (target_var),
    .src_is_var  (src_is_var),
    .src_var     (src_var),
    .literal     (literal),
    .cmp_op      (cmp_op),
    .line        (line),
    .cmd         (cmd),
    .stat        (stat),
    .out_full    (out_full),
    .out_take    (out_full && !out_stall),
    .counter_now (counter_now),
    .print_valid (print_valid),
    .print_index (print_index),
    .print_value (print_value),
    .error       (error),
    .last        (last)
  );

endmodule
